/* rtl/sead_pkg.sv */
// shared constants, register map and configuration type of the angle command deframer
`timescale 1ns / 1ps

package sead_pkg;

  // geometry
  localparam int unsigned BUFFER_DEPTH_DEF = 64;
  localparam int unsigned CHUNK_MAX        = 20;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned LEN_W            = 5;
  localparam int unsigned ANGLE_W          = 10;
  localparam int unsigned FRAME_END_OFS    = 5;

  // register port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_ANGLE    = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0]  START_MARKER_RST = 8'h40;
  localparam logic [BYTE_W-1:0]  END_MARKER_RST   = 8'h21;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST    = 10'd180;

  typedef struct packed {
    logic [BYTE_W-1:0]  start_marker;
    logic [BYTE_W-1:0]  end_marker;
    logic [ANGLE_W-1:0] max_angle;
  } cfg_t;

endpackage

/* rtl/sead_if.sv */
// valid/ready channel interfaces for received bytes and decoded results
`timescale 1ns / 1ps

interface sead_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [4:0] chunk_len;
  logic       last_in_chunk;

  modport source (output valid, output rx_byte, output chunk_len, output last_in_chunk,
                  input ready);
  modport sink (input valid, input rx_byte, input chunk_len, input last_in_chunk,
                output ready);
endinterface

interface sead_out_if;
  logic       valid;
  logic       ready;
  logic       frame_taken;
  logic       angle_valid;
  logic [9:0] angle;

  modport source (output valid, output frame_taken, output angle_valid, output angle,
                  input ready);
  modport sink (input valid, input frame_taken, input angle_valid, input angle,
                output ready);
endinterface

/* rtl/sead_byte_store.sv */
// circular byte store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module sead_byte_store #(
  parameter int unsigned BUFFER_DEPTH = sead_pkg::BUFFER_DEPTH_DEF,
  localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [PTR_W-1:0]            wr_addr_i,
  input  logic [sead_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [PTR_W-1:0]            rd_addr_i,
  output logic [sead_pkg::BYTE_W-1:0] rd_data_o
);

  logic [sead_pkg::BYTE_W-1:0] mem_q [BUFFER_DEPTH];
  logic [sead_pkg::BYTE_W-1:0] rd_data_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/sead_num_parse.sv */
// decimal reader for the three frame characters: blanks, optional sign, digits
`timescale 1ns / 1ps

module sead_num_parse (
  input  logic [2:0][sead_pkg::BYTE_W-1:0] chars_i,
  output logic                             ok_o,
  output logic [sead_pkg::ANGLE_W-1:0]     value_o
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_NUM,
    PH_STOP
  } phase_e;

  phase_e                       phase;
  logic                         neg;
  logic                         seen;
  logic [sead_pkg::ANGLE_W-1:0] acc;
  logic [7:0]                   c;
  logic                         blank;
  logic                         digit;
  logic                         sign;

  // walk the three characters in order
  always_comb begin
    phase = PH_BLANK;
    neg   = 1'b0;
    seen  = 1'b0;
    acc   = '0;
    c     = '0;
    blank = 1'b0;
    digit = 1'b0;
    sign  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      c     = chars_i[k];
      blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      sign  = (c == CH_PLUS) || (c == CH_MINUS);
      unique case (phase)
        PH_BLANK: begin
          if (blank) begin
            phase = PH_BLANK;
          end else if (sign) begin
            neg   = (c == CH_MINUS);
            phase = PH_NUM;
          end else if (digit) begin
            acc   = sead_pkg::ANGLE_W'(c - CH_ZERO);
            seen  = 1'b1;
            phase = PH_NUM;
          end else begin
            phase = PH_STOP;
          end
        end
        PH_NUM: begin
          if (digit) begin
            acc  = sead_pkg::ANGLE_W'(acc * 4'd10) + sead_pkg::ANGLE_W'(c - CH_ZERO);
            seen = 1'b1;
          end else begin
            phase = PH_STOP;
          end
        end
        PH_STOP: begin
          phase = PH_STOP;
        end
        default: begin
          phase = PH_STOP;
        end
      endcase
    end
  end

  // minus zero still reads as zero
  assign ok_o    = seen && !(neg && (acc != '0));
  assign value_o = acc;

endmodule

/* rtl/sead_seq.sv */
// sequencer with shared wrap-around address adder, byte store and frame decoding
`timescale 1ns / 1ps

module sead_seq #(
  parameter int unsigned BUFFER_DEPTH = sead_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sead_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sead_pkg::BYTE_W-1:0]  rx_byte_i,
  input  logic [sead_pkg::LEN_W-1:0]   chunk_len_i,
  input  logic                         last_in_chunk_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         frame_taken_o,
  output logic                         angle_valid_o,
  output logic [sead_pkg::ANGLE_W-1:0] angle_o
);

  localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned OFS_W = 3;

  localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(BUFFER_DEPTH);
  localparam logic [SUM_W-1:0] ROOM_LIM   = SUM_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] HALF_C     = CNT_W'(BUFFER_DEPTH / 2);
  localparam logic [CNT_W-1:0] END_OFS_C  = CNT_W'(sead_pkg::FRAME_END_OFS);
  localparam logic [CNT_W-1:0] FRAME_LEN  = CNT_W'(sead_pkg::FRAME_END_OFS + 1);
  localparam logic [OFS_W-1:0] END_OFS_O  = OFS_W'(sead_pkg::FRAME_END_OFS);
  localparam logic [OFS_W-1:0] CHAR_LO    = 3'd2;
  localparam logic [OFS_W-1:0] FIRST_OFS  = 3'd1;
  localparam logic [5:0]       CHUNK_LIM  = 6'(sead_pkg::CHUNK_MAX);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADMIT,
    S_WRITE,
    S_SCAN,
    S_ALIGN,
    S_FRAME,
    S_EVAL,
    S_FINISH,
    S_EMIT
  } state_e;

  state_e                             state_q, state_d;
  logic [PTR_W-1:0]                   head_q, head_d;
  logic [CNT_W-1:0]                   fill_q, fill_d;
  logic                               dropped_q, dropped_d;
  logic                               at_start_q, at_start_d;
  logic [sead_pkg::BYTE_W-1:0]        byte_q, byte_d;
  logic [sead_pkg::LEN_W-1:0]         len_q, len_d;
  logic                               last_q, last_d;
  logic [CNT_W-1:0]                   idx_q, idx_d;
  logic                               rd_pend_q, rd_pend_d;
  logic [CNT_W-1:0]                   rd_idx_q, rd_idx_d;
  logic [OFS_W-1:0]                   off_q, off_d;
  logic [OFS_W-1:0]                   rd_off_q, rd_off_d;
  logic                               end_hit_q, end_hit_d;
  logic                               end5_q, end5_d;
  logic [2:0][sead_pkg::BYTE_W-1:0]   ch_q, ch_d;
  logic                               frame_q, frame_d;
  logic                               pr_ok_q, pr_ok_d;
  logic [sead_pkg::ANGLE_W-1:0]       pr_val_q, pr_val_d;
  logic                               res_frame_q, res_frame_d;
  logic                               res_valid_q, res_valid_d;
  logic [sead_pkg::ANGLE_W-1:0]       res_angle_q, res_angle_d;
  logic                               out_valid_q, out_valid_d;
  logic                               out_frame_q, out_frame_d;
  logic                               out_avalid_q, out_avalid_d;
  logic [sead_pkg::ANGLE_W-1:0]       out_angle_q, out_angle_d;

  logic [CNT_W-1:0]                   add_b;
  logic [SUM_W-1:0]                   add_sum;
  logic [PTR_W-1:0]                   add_wrap;
  logic                               mem_wr_en;
  logic                               mem_rd_en;
  logic [sead_pkg::BYTE_W-1:0]        rd_data;
  logic                               hit_start;
  logic                               hit_end;
  logic                               room_short;
  logic                               len_over;
  logic [CNT_W-1:0]                   fill_align;
  logic                               pr_ok;
  logic [sead_pkg::ANGLE_W-1:0]       pr_val;

  // shared adder operand: what is added to the head pointer in each step
  always_comb begin
    unique case (state_q)
      S_ADMIT:  add_b = fill_q >> 1;
      S_WRITE:  add_b = fill_q;
      S_SCAN:   add_b = idx_q;
      S_ALIGN:  add_b = idx_q;
      S_FRAME:  add_b = CNT_W'(off_q);
      S_FINISH: add_b = END_OFS_C;
      default:  add_b = '0;
    endcase
  end

  // shared wrap-around adder, both operands below the depth or equal to it
  assign add_sum  = SUM_W'(head_q) + SUM_W'(add_b);
  assign add_wrap = (add_sum >= DEPTH_S) ? PTR_W'(add_sum - DEPTH_S) : PTR_W'(add_sum);

  sead_byte_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (add_wrap),
    .wr_data_i (byte_q),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (add_wrap),
    .rd_data_o (rd_data)
  );

  sead_num_parse u_parse (
    .chars_i (ch_q),
    .ok_o    (pr_ok),
    .value_o (pr_val)
  );

  assign hit_start  = (rd_data == cfg_i.start_marker);
  assign hit_end    = (rd_data == cfg_i.end_marker);
  assign len_over   = ({1'b0, len_q} > CHUNK_LIM);
  assign room_short = (SUM_W'(fill_q) + SUM_W'(len_q)) >= ROOM_LIM;
  assign fill_align = fill_q - idx_q;

  // next-state logic
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    dropped_d    = dropped_q;
    at_start_d   = at_start_q;
    byte_d       = byte_q;
    len_d        = len_q;
    last_d       = last_q;
    idx_d        = idx_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    off_d        = off_q;
    rd_off_d     = rd_off_q;
    end_hit_d    = end_hit_q;
    end5_d       = end5_q;
    ch_d         = ch_q;
    frame_d      = frame_q;
    pr_ok_d      = pr_ok_q;
    pr_val_d     = pr_val_q;
    res_frame_d  = res_frame_q;
    res_valid_d  = res_valid_q;
    res_angle_d  = res_angle_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_frame_d  = out_frame_q;
    out_avalid_d = out_avalid_q;
    out_angle_d  = out_angle_q;
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      // wait for a byte
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          byte_d  = rx_byte_i;
          len_d   = chunk_len_i;
          last_d  = last_in_chunk_i;
          state_d = S_ADMIT;
        end
      end

      // chunk admission on its first byte; a chunk that does not fit halves the store
      S_ADMIT: begin
        if (at_start_q) begin
          if (len_over) begin
            dropped_d = 1'b1;
          end else if (room_short) begin
            dropped_d = 1'b1;
            head_d    = add_wrap;
            fill_d    = fill_q - (fill_q >> 1);
          end else begin
            dropped_d = 1'b0;
          end
        end
        at_start_d = last_q;
        state_d    = S_WRITE;
      end

      // append the byte behind the held ones
      S_WRITE: begin
        if (!dropped_q && (fill_q < DEPTH_C)) begin
          mem_wr_en = 1'b1;
          fill_d    = fill_q + 1'b1;
        end
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          dropped_d   = 1'b0;
          res_frame_d = 1'b0;
          res_valid_d = 1'b0;
          res_angle_d = '0;
          idx_d       = '0;
          state_d     = dropped_q ? S_EMIT : S_SCAN;
        end
      end

      // look for the first start marker, one read issued per cycle
      S_SCAN: begin
        if (rd_pend_q && hit_start) begin
          idx_d   = rd_idx_q;
          state_d = S_ALIGN;
        end else if (idx_q >= fill_q) begin
          if (fill_q > HALF_C) begin
            fill_d = '0;
          end
          state_d = S_EMIT;
        end else begin
          mem_rd_en = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = idx_q;
          idx_d     = idx_q + 1'b1;
        end
      end

      // drop the bytes in front of the start marker
      S_ALIGN: begin
        head_d    = add_wrap;
        fill_d    = fill_align;
        off_d     = FIRST_OFS;
        end_hit_d = (cfg_i.start_marker == cfg_i.end_marker);
        end5_d    = 1'b0;
        state_d   = (fill_align < FRAME_LEN) ? S_EMIT : S_FRAME;
      end

      // fetch offsets one to five behind the start marker
      S_FRAME: begin
        if (rd_pend_q) begin
          if (rd_off_q == END_OFS_O) begin
            end5_d  = hit_end;
            state_d = S_EVAL;
          end else begin
            end_hit_d = end_hit_q || hit_end;
            if (rd_off_q >= CHAR_LO) begin
              ch_d[2'(rd_off_q - CHAR_LO)] = rd_data;
            end
          end
        end
        if (off_q <= END_OFS_O) begin
          mem_rd_en = 1'b1;
          rd_pend_d = 1'b1;
          rd_off_d  = off_q;
          off_d     = off_q + 1'b1;
        end
      end

      // frame check and number decode
      S_EVAL: begin
        frame_d  = !end_hit_q && end5_q;
        pr_ok_d  = pr_ok;
        pr_val_d = pr_val;
        state_d  = S_FINISH;
      end

      // range check and consume up to the end marker
      S_FINISH: begin
        if (frame_q) begin
          res_frame_d = 1'b1;
          if (pr_ok_q && (pr_val_q <= cfg_i.max_angle)) begin
            res_valid_d = 1'b1;
            res_angle_d = pr_val_q;
          end
          head_d = add_wrap;
          fill_d = fill_q - END_OFS_C;
        end
        state_d = S_EMIT;
      end

      // hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_frame_d  = res_frame_q;
          out_avalid_d = res_valid_q;
          out_angle_d  = res_angle_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      dropped_q    <= 1'b0;
      at_start_q   <= 1'b1;
      byte_q       <= '0;
      len_q        <= '0;
      last_q       <= 1'b0;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_idx_q     <= '0;
      off_q        <= '0;
      rd_off_q     <= '0;
      end_hit_q    <= 1'b0;
      end5_q       <= 1'b0;
      ch_q         <= '0;
      frame_q      <= 1'b0;
      pr_ok_q      <= 1'b0;
      pr_val_q     <= '0;
      res_frame_q  <= 1'b0;
      res_valid_q  <= 1'b0;
      res_angle_q  <= '0;
      out_valid_q  <= 1'b0;
      out_frame_q  <= 1'b0;
      out_avalid_q <= 1'b0;
      out_angle_q  <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      dropped_q    <= dropped_d;
      at_start_q   <= at_start_d;
      byte_q       <= byte_d;
      len_q        <= len_d;
      last_q       <= last_d;
      idx_q        <= idx_d;
      rd_pend_q    <= rd_pend_d;
      rd_idx_q     <= rd_idx_d;
      off_q        <= off_d;
      rd_off_q     <= rd_off_d;
      end_hit_q    <= end_hit_d;
      end5_q       <= end5_d;
      ch_q         <= ch_d;
      frame_q      <= frame_d;
      pr_ok_q      <= pr_ok_d;
      pr_val_q     <= pr_val_d;
      res_frame_q  <= res_frame_d;
      res_valid_q  <= res_valid_d;
      res_angle_q  <= res_angle_d;
      out_valid_q  <= out_valid_d;
      out_frame_q  <= out_frame_d;
      out_avalid_q <= out_avalid_d;
      out_angle_q  <= out_angle_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_taken_o = out_frame_q;
  assign angle_valid_o = out_avalid_q;
  assign angle_o       = out_angle_q;

endmodule

/* rtl/stx_etx_angle_command_deframer.sv */
// A byte that does not close its chunk holds the input through the admit and write states.
// For a closing byte the search for the start marker follows, reading the byte store one
// byte a cycle; five reads then fetch the frame, followed by evaluate, finish and emit.
// A dropped chunk goes straight to emit. The search covers the held bytes, 64 at most.
// Throughput: one byte at a time; the result waits in an output register.
// Reset: asynchronous, active low; clears pointers, fill count and flags and loads
// the register defaults; store contents stay undefined and are never cleared.
`timescale 1ns / 1ps

module stx_etx_angle_command_deframer #(
  parameter int unsigned BUFFER_DEPTH = sead_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sead_in_if.sink                       in_i,
  sead_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sead_pkg::PADDR_W-1:0]  paddr,
  input  logic [sead_pkg::PDATA_W-1:0]  pwdata,
  output logic [sead_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  sead_pkg::cfg_t cfg_q;
  logic           cfg_wr;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[sead_pkg::PADDR_W-1:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= sead_pkg::START_MARKER_RST;
      cfg_q.end_marker   <= sead_pkg::END_MARKER_RST;
      cfg_q.max_angle    <= sead_pkg::MAX_ANGLE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sead_pkg::REG_START_MARKER: cfg_q.start_marker <= pwdata[sead_pkg::BYTE_W-1:0];
        sead_pkg::REG_END_MARKER:   cfg_q.end_marker   <= pwdata[sead_pkg::BYTE_W-1:0];
        sead_pkg::REG_MAX_ANGLE:    cfg_q.max_angle    <= pwdata[sead_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      sead_pkg::REG_START_MARKER: prdata = sead_pkg::PDATA_W'(cfg_q.start_marker);
      sead_pkg::REG_END_MARKER:   prdata = sead_pkg::PDATA_W'(cfg_q.end_marker);
      sead_pkg::REG_MAX_ANGLE:    prdata = sead_pkg::PDATA_W'(cfg_q.max_angle);
      default:                    prdata = '0;
    endcase
  end

  // byte sequencer and frame decoder
  sead_seq #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .rx_byte_i       (in_i.rx_byte),
    .chunk_len_i     (in_i.chunk_len),
    .last_in_chunk_i (in_i.last_in_chunk),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .frame_taken_o   (out_o.frame_taken),
    .angle_valid_o   (out_o.angle_valid),
    .angle_o         (out_o.angle)
  );

`ifndef SYNTHESIS
  // the block is busy in the cycle after every input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input still ready right after a transfer");

  // a new result only appears after a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result raised while the block was idle");

  // a byte that does not close its chunk yields no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && !in_i.last_in_chunk
      |=> !$rose(out_o.valid) ##1 !$rose(out_o.valid) ##1 !$rose(out_o.valid))
    else $error("result raised for a byte inside a chunk");
`endif

endmodule
